### rtl/core/tspm_pkg.sv
// Package with the item types, register map, constants and cosine table of the modulator.
`timescale 1ns / 1ps
package tspm_pkg;

  localparam int FREQ_SCALE     = 256;
  localparam int COS_TABLE_BITS = 10;

  // Quarter-wave table geometry.
  localparam int QTR_BITS  = COS_TABLE_BITS - 2;
  localparam int QTR_DEPTH = (1 << QTR_BITS) + 1;
  localparam int IDX_W     = QTR_BITS + 1;
  localparam int ANG_LSB   = 16 - COS_TABLE_BITS;

  // Divider geometry: (freq << 32) / (pwm_rate * FREQ_SCALE).
  localparam int DVD_W     = 48;
  localparam int DVS_W     = 32;
  localparam int CNT_W     = $clog2(DVD_W);

  localparam longint COEF_A  = 1324675879;
  localparam longint COEF_B  = 272375560;
  localparam longint COEF_C  = 22401992;
  localparam longint COEF_D  = 987048;
  localparam longint ONE_Q30 = 1073741824;

  // Reciprocal of six for magnitudes below 2^15.
  localparam logic [15:0] RECIP6 = 16'd43691;

  localparam logic [2:0] REG_PWM_RATE       = 3'd0;
  localparam logic [2:0] REG_HALF_PERIOD    = 3'd1;
  localparam logic [2:0] REG_PHASE_SHIFT    = 3'd2;
  localparam logic [2:0] REG_THIRD_HARMONIC = 3'd3;
  localparam logic [2:0] REG_INVERT_SINE    = 3'd4;

  typedef struct packed {
    logic        [15:0] freq_command;
    logic signed [15:0] amplitude;
  } in_item_t;

  typedef struct packed {
    logic [16:0] width_a;
    logic [16:0] width_b;
    logic [16:0] width_c;
    logic [15:0] angle;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_LK1,
    S_LK3,
    S_MUL,
    S_FIN,
    S_DONE
  } state_t;

  typedef logic [14:0] cos_lut_t [QTR_DEPTH];

  // Polynomial quarter cosine in unsigned Q0.15, evaluated only at elaboration.
  function automatic logic [14:0] quarter_cos(input longint t);
    longint x;
    longint x2;
    longint h;
    longint c;
    x  = t <<< 16;
    x2 = (x * x) >>> 30;
    h  = COEF_C - ((x2 * COEF_D) >>> 30);
    h  = COEF_B - ((x2 * h) >>> 30);
    h  = COEF_A - ((x2 * h) >>> 30);
    c  = ONE_Q30 - ((x2 * h) >>> 30);
    c  = (c + 16384) / 32768;
    if (c < 0) c = 0;
    if (c > 32767) c = 32767;
    return c[14:0];
  endfunction

  function automatic cos_lut_t build_lut();
    cos_lut_t lut;
    for (int i = 0; i < QTR_DEPTH; i++) begin
      lut[i] = quarter_cos(longint'(i) <<< ANG_LSB);
    end
    return lut;
  endfunction

  localparam cos_lut_t COS_LUT = build_lut();

endpackage

### rtl/core/three_phase_sine_pwm_modulator_unit.sv
// Three-phase sine PWM modulator: phase divider, cosine lookups and width sequencer.
`timescale 1ns / 1ps
//  Channel | Direction | Handshake             | Payload
//  in      | input     | in_valid / in_stall   | tspm_pkg::in_item_t
//  out     | output    | out_valid / out_stall | tspm_pkg::out_item_t
//  cfg     | input     | APB psel / penable    | 32-bit registers at 4*i
// out_valid rises after an accepted item has passed the bit-serial phase increment
// divider, then per phase two table reads, a multiply and saturation, and last the
// load of the output register once it is free. A new item is taken only in the idle
// state, in the cycle after the result is loaded into the output register, even
// while that result is stalled.
// Reset is synchronous on rst and restores the register defaults and a zero phase.
module three_phase_sine_pwm_modulator_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  tspm_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tspm_pkg::out_item_t  out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  tspm_pkg::state_t state, state_next;

  logic [15:0] pwm_rate;
  logic [15:0] half_period;
  logic [15:0] phase_shift;
  logic        third_harmonic;
  logic        invert_sine;

  logic [31:0]                  phase_accum;
  logic signed [15:0]           amp;
  logic [tspm_pkg::DVD_W-1:0]   dq;
  logic [tspm_pkg::DVS_W-1:0]   divisor;
  logic [tspm_pkg::DVS_W-1:0]   rem;
  logic [tspm_pkg::CNT_W-1:0]   cnt;
  logic [1:0]                   ph;
  logic [14:0]                  tab;
  logic                         tab_neg;
  logic signed [15:0]           c1;
  logic signed [32:0]           prod;
  logic [16:0]                  width [3];

  logic                         accept;
  logic                         cfg_wr;
  logic [tspm_pkg::DVS_W:0]     rem_s;
  logic                         qbit;
  logic [tspm_pkg::DVD_W-1:0]   dq_shift;
  logic [tspm_pkg::DVS_W-1:0]   rem_upd;
  logic [31:0]                  inc;
  logic [15:0]                  cur_ang;
  logic [15:0]                  look_ang;
  logic [tspm_pkg::IDX_W-1:0]   look_idx;
  logic                         look_neg;
  logic [14:0]                  c3_mag;
  logic [30:0]                  c3_scaled;
  logic signed [15:0]           c3_div6;
  logic signed [16:0]           m;
  logic [32:0]                  prod_mag;
  logic signed [18:0]           v;
  logic signed [18:0]           lim;
  logic signed [18:0]           v_sat;
  logic                         out_load;

  assign accept = in_valid && !in_stall;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign in_stall = (state != tspm_pkg::S_IDLE);

  always_comb begin
    unique case (paddr[4:2])
      tspm_pkg::REG_PWM_RATE:       prdata = {16'd0, pwm_rate};
      tspm_pkg::REG_HALF_PERIOD:    prdata = {16'd0, half_period};
      tspm_pkg::REG_PHASE_SHIFT:    prdata = {16'd0, phase_shift};
      tspm_pkg::REG_THIRD_HARMONIC: prdata = {31'd0, third_harmonic};
      tspm_pkg::REG_INVERT_SINE:    prdata = {31'd0, invert_sine};
      default:                      prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_rate       <= 16'd5000;
      half_period    <= 16'd3000;
      phase_shift    <= 16'd21845;
      third_harmonic <= 1'b0;
      invert_sine    <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        tspm_pkg::REG_PWM_RATE:       pwm_rate       <= pwdata[15:0];
        tspm_pkg::REG_HALF_PERIOD:    half_period    <= pwdata[15:0];
        tspm_pkg::REG_PHASE_SHIFT:    phase_shift    <= pwdata[15:0];
        tspm_pkg::REG_THIRD_HARMONIC: third_harmonic <= pwdata[0];
        tspm_pkg::REG_INVERT_SINE:    invert_sine    <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Restoring division, one quotient bit per cycle; dq holds dividend and quotient.
  assign rem_s    = {rem, dq[tspm_pkg::DVD_W-1]};
  assign qbit     = (rem_s >= {1'b0, divisor});
  assign rem_upd  = qbit ? tspm_pkg::DVS_W'(rem_s - {1'b0, divisor})
                         : rem_s[tspm_pkg::DVS_W-1:0];
  assign dq_shift = {dq[tspm_pkg::DVD_W-2:0], qbit};
  // A zero divisor would give all ones; the increment is zero then.
  assign inc      = (divisor == '0) ? 32'd0 : dq_shift[31:0];

  always_comb begin
    unique case (ph)
      2'd1:    cur_ang = phase_accum[31:16] - phase_shift;
      2'd2:    cur_ang = phase_accum[31:16] + phase_shift;
      default: cur_ang = phase_accum[31:16];
    endcase
  end

  // The third harmonic angle is 3a modulo one turn.
  assign look_ang = (state == tspm_pkg::S_LK3) ? 16'(cur_ang + {cur_ang[14:0], 1'b0})
                                               : cur_ang;
  assign look_neg = look_ang[15] ^ look_ang[14];
  always_comb begin
    if (look_ang[14]) begin
      look_idx = tspm_pkg::IDX_W'(1 << tspm_pkg::QTR_BITS)
               - {1'b0, look_ang[13:tspm_pkg::ANG_LSB]};
    end else begin
      look_idx = {1'b0, look_ang[13:tspm_pkg::ANG_LSB]};
    end
  end

  // Signed division by six, truncated toward zero, through a reciprocal.
  assign c3_mag    = tab;
  assign c3_scaled = c3_mag * tspm_pkg::RECIP6;
  assign c3_div6   = tab_neg ? -$signed({3'd0, c3_scaled[30:18]})
                             : $signed({3'd0, c3_scaled[30:18]});
  assign m = third_harmonic ? (17'(c1) - 17'(c3_div6)) : 17'(c1);

  assign prod_mag = prod[32] ? 33'(-prod) : 33'(prod);
  always_comb begin
    v = prod[32] ? -$signed({1'b0, prod_mag[32:15]}) : $signed({1'b0, prod_mag[32:15]});
    if (invert_sine) v = -v;
  end
  assign lim   = $signed({3'd0, half_period});
  assign v_sat = (v > lim) ? lim : ((v < -lim) ? -lim : v);

  assign out_load = (state == tspm_pkg::S_DONE) && (!out_valid || !out_stall);

  always_comb begin
    state_next = state;
    unique case (state)
      tspm_pkg::S_IDLE: if (accept) state_next = tspm_pkg::S_DIV;
      tspm_pkg::S_DIV: begin
        if (cnt == tspm_pkg::CNT_W'(tspm_pkg::DVD_W - 1)) state_next = tspm_pkg::S_LK1;
      end
      tspm_pkg::S_LK1: state_next = tspm_pkg::S_LK3;
      tspm_pkg::S_LK3: state_next = tspm_pkg::S_MUL;
      tspm_pkg::S_MUL: state_next = tspm_pkg::S_FIN;
      tspm_pkg::S_FIN: state_next = (ph == 2'd2) ? tspm_pkg::S_DONE : tspm_pkg::S_LK1;
      tspm_pkg::S_DONE: if (out_load) state_next = tspm_pkg::S_IDLE;
      default: state_next = tspm_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= tspm_pkg::S_IDLE;
      phase_accum <= 32'd0;
      out_valid   <= 1'b0;
      cnt         <= '0;
      ph          <= 2'd0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        tspm_pkg::S_IDLE: begin
          cnt <= '0;
          ph  <= 2'd0;
        end
        tspm_pkg::S_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == tspm_pkg::CNT_W'(tspm_pkg::DVD_W - 1)) begin
            phase_accum <= phase_accum + inc;
          end
        end
        tspm_pkg::S_FIN: ph <= ph + 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      tspm_pkg::S_IDLE: begin
        dq      <= {in_data.freq_command, 32'd0};
        divisor <= tspm_pkg::DVS_W'(pwm_rate * tspm_pkg::FREQ_SCALE);
        rem     <= '0;
        amp     <= in_data.amplitude;
      end
      tspm_pkg::S_DIV: begin
        dq  <= dq_shift;
        rem <= rem_upd;
      end
      tspm_pkg::S_LK1: begin
        tab     <= tspm_pkg::COS_LUT[look_idx];
        tab_neg <= look_neg;
      end
      tspm_pkg::S_LK3: begin
        c1      <= tab_neg ? -$signed({1'b0, tab}) : $signed({1'b0, tab});
        tab     <= tspm_pkg::COS_LUT[look_idx];
        tab_neg <= look_neg;
      end
      tspm_pkg::S_MUL: prod <= m * amp;
      tspm_pkg::S_FIN: width[ph] <= 17'(lim - v_sat);
      default: ;
    endcase
    if (out_load) begin
      out_data.width_a <= width[0];
      out_data.width_b <= width[1];
      out_data.width_c <= width[2];
      out_data.angle   <= phase_accum[31:16];
    end
  end

`ifndef SYNTHESIS
  a_busy_stalls: assert property (@(posedge clk) disable iff (rst)
    (state != tspm_pkg::S_IDLE) |-> in_stall)
    else $error("input taken while an item is in progress");

  a_accept_divides: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == tspm_pkg::S_DIV))
    else $error("accepted item did not start the divider");

  a_result_retires: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && state != tspm_pkg::S_DONE) |=> !out_valid)
    else $error("taken result was repeated");

  a_done_after_phase_c: assert property (@(posedge clk) disable iff (rst)
    (state == tspm_pkg::S_FIN && ph == 2'd2) |=> (state == tspm_pkg::S_DONE))
    else $error("sequencer skipped the result stage");
`endif

endmodule

### tb/sv/tb_three_phase_sine_pwm_modulator_unit.sv
// Self-checking testbench for the three-phase sine PWM modulator unit.
`timescale 1ns / 1ps
module tb_three_phase_sine_pwm_modulator_unit;

  localparam int LATENCY     = 70;
  localparam int CYCLE_LIMIT = 400000;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  tspm_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  tspm_pkg::out_item_t out_data;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [4:0]          paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  three_phase_sine_pwm_modulator_unit dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state and register shadows.
  logic [15:0] rate_q = 16'd5000;
  logic [15:0] half_q = 16'd3000;
  logic [15:0] shift_q = 16'd21845;
  logic        harm_q = 1'b0;
  logic        inv_q = 1'b0;
  logic [31:0] accum_q = '0;

  tspm_pkg::out_item_t width_queue[$];
  int          mismatches = 0;
  int          items_sent = 0;
  int          results_seen = 0;
  int          cycles = 0;
  int          rx_wait = 0;
  bit          long_hold = 1'b0;
  bit          rx_random = 1'b1;

  function automatic longint quarter_wave(longint t);
    longint x, x2, h, c;
    x  = t <<< 16;
    x2 = (x * x) >>> 30;
    h  = tspm_pkg::COEF_C - ((x2 * tspm_pkg::COEF_D) >>> 30);
    h  = tspm_pkg::COEF_B - ((x2 * h) >>> 30);
    h  = tspm_pkg::COEF_A - ((x2 * h) >>> 30);
    c  = tspm_pkg::ONE_Q30 - ((x2 * h) >>> 30);
    c  = (c + 16384) / 32768;
    if (c < 0) c = 0;
    if (c > 32767) c = 32767;
    return c;
  endfunction

  function automatic longint cosine_q15(logic [15:0] ang);
    logic [15:0] p;
    logic [1:0]  q;
    longint      r;
    p = (ang >> tspm_pkg::ANG_LSB) << tspm_pkg::ANG_LSB;
    q = p[15:14];
    r = p[13:0];
    case (q)
      2'd0: return quarter_wave(r);
      2'd1: return -quarter_wave(16384 - r);
      2'd2: return -quarter_wave(r);
      default: return quarter_wave(16384 - r);
    endcase
  endfunction

  function automatic logic [16:0] width_at(logic [15:0] ang, longint amp);
    longint m, prod, v, lim;
    logic [15:0] a3;
    m = cosine_q15(ang);
    a3 = ang * 16'd3;
    if (harm_q) m = m - cosine_q15(a3) / 6;
    prod = m * amp;
    v = prod >= 0 ? prod / 32768 : -((-prod) / 32768);
    if (inv_q) v = -v;
    lim = half_q;
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    return 17'(lim - v);
  endfunction

  function automatic tspm_pkg::out_item_t predict_widths(tspm_pkg::in_item_t it);
    logic [63:0] dvs, incr;
    logic [15:0] ang;
    longint      amp;
    tspm_pkg::out_item_t r;
    dvs = 64'(rate_q) * tspm_pkg::FREQ_SCALE;
    incr = 0;
    if (dvs != 0 && it.freq_command != 0) incr = (64'(it.freq_command) << 32) / dvs;
    accum_q = accum_q + incr[31:0];
    ang = accum_q[31:16];
    amp = it.amplitude;
    r.width_a = width_at(ang, amp);
    r.width_b = width_at(ang - shift_q, amp);
    r.width_c = width_at(ang + shift_q, amp);
    r.angle = ang;
    return r;
  endfunction

  task automatic send_item(logic [15:0] f, logic [15:0] a);
    tspm_pkg::in_item_t it;
    int gap;
    gap = $urandom_range(0, 4);
    repeat (gap) @(negedge clk);
    it.freq_command = f;
    it.amplitude = a;
    in_data = it;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    width_queue.push_back(predict_widths(it));
    items_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (width_queue.size() != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    psel = 1'b1; pwrite = 1'b1; paddr = {idx, 2'b00}; pwdata = val; penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      tspm_pkg::REG_PWM_RATE:       rate_q = val[15:0];
      tspm_pkg::REG_HALF_PERIOD:    half_q = val[15:0];
      tspm_pkg::REG_PHASE_SHIFT:    shift_q = val[15:0];
      tspm_pkg::REG_THIRD_HARMONIC: harm_q = val[0];
      tspm_pkg::REG_INVERT_SINE:    inv_q = val[0];
      default: ;
    endcase
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  task automatic set_all(logic [15:0] r, logic [15:0] h, logic [15:0] s, bit th, bit iv);
    wait_drained();
    write_reg(tspm_pkg::REG_PWM_RATE, r);
    write_reg(tspm_pkg::REG_HALF_PERIOD, h);
    write_reg(tspm_pkg::REG_PHASE_SHIFT, s);
    write_reg(tspm_pkg::REG_THIRD_HARMONIC, th);
    write_reg(tspm_pkg::REG_INVERT_SINE, iv);
  endtask

  task automatic test_directed();
    send_item(16'd0, 16'd0);
    send_item(16'hFFFF, 16'h7FFF);
    send_item(16'hFFFF, 16'h8000);
    send_item(16'd1, 16'hFFFF);
    send_item(16'd12800, 16'd3000);
    set_all(16'd1, 16'd65535, 16'h8000, 1'b1, 1'b1);
    send_item(16'hFFFF, 16'h7FFF);
    send_item(16'h8000, 16'h8000);
    send_item(16'd256, 16'h5555);
    // Zero divisor and zero half period.
    set_all(16'd0, 16'd0, 16'h7FFF, 1'b0, 1'b0);
    send_item(16'hFFFF, 16'h7FFF);
    send_item(16'h1234, 16'h8000);
    set_all(16'd65535, 16'd1, 16'd0, 1'b1, 1'b0);
    send_item(16'hFFFF, 16'h7FFF);
    send_item(16'd1, 16'h8001);
    set_all(16'd50, 16'd32768, 16'd21845, 1'b0, 1'b1);
    send_item(16'd777, 16'h4000);
    send_item(16'hAAAA, 16'hC000);
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      send_item(16'($urandom()), 16'($urandom()));
    end
  endtask

  task automatic test_settings();
    for (int k = 0; k < 6; k++) begin
      set_all(16'($urandom_range(1, 65535)), 16'($urandom()), 16'($urandom()),
              1'($urandom()), 1'($urandom()));
      test_random(100);
    end
  endtask

  task automatic test_backpressure();
    long_hold = 1'b1;
    fork
      begin
        repeat (400) @(negedge clk);
        long_hold = 1'b0;
      end
      test_random(6);
    join
  endtask

  // Receiver stall pattern: a drawn wait for every offered item, a long hold, or no stall.
  always @(negedge clk) begin
    if (long_hold) out_stall <= 1'b1;
    else if (rx_random) out_stall <= (rx_wait != 0);
    else out_stall <= 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && out_valid && !out_stall) begin
      rx_wait <= $urandom_range(0, 4);
      if (width_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data);
      end else begin
        tspm_pkg::out_item_t e;
        e = width_queue.pop_front();
        results_seen++;
        if (e.width_a !== out_data.width_a || e.width_b !== out_data.width_b ||
            e.width_c !== out_data.width_c || e.angle !== out_data.angle) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp a=%0d b=%0d c=%0d ang=%0d got a=%0d b=%0d c=%0d ang=%0d",
                     e.width_a, e.width_b, e.width_c, e.angle, out_data.width_a,
                     out_data.width_b, out_data.width_c, out_data.angle);
        end
      end
    end else if (out_valid && rx_wait != 0) begin
      rx_wait <= rx_wait - 1;
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    set_all(16'd5000, 16'd3000, 16'd21845, 1'b0, 1'b0);
    test_backpressure();
    test_settings();
    rx_random = 1'b0;
    test_random(40);
    wait_drained();
    if (width_queue.size() != 0) mismatches++;
    $display("Sent %0d items and checked %0d results over several register settings,",
             items_sent, results_seen);
    $display("with random gaps, receiver stalls and one long hold-off.");
    if (mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

### three_phase_sine_pwm_modulator_unit.f
rtl/core/tspm_pkg.sv
rtl/core/three_phase_sine_pwm_modulator_unit.sv
tb/sv/tb_three_phase_sine_pwm_modulator_unit.sv
